// ----- rtl/core/wtbh_pkg.sv -----
// word tokenizer bucket hash: shared types, constants and the delimiter decode
// no dependencies
`default_nettype none

package wtbh_pkg;

	localparam int unsigned REM_W   = 36;
	localparam int unsigned MAG_W   = 30;
	localparam int unsigned BKT_W   = 25;
	localparam int unsigned IDX_W   = 24;
	localparam int unsigned CNT_W   = 5;

	localparam logic [REM_W-1:0] HASH_MOD   = 36'd1000000009;
	localparam logic [BKT_W-1:0] BUCKET_MAX = 25'd16777216;
	localparam logic [CNT_W-1:0] HRED_TOP   = 5'd4;
	localparam logic [CNT_W-1:0] BRED_TOP   = 5'd29;

	localparam logic [7:0] UPPER_A  = 8'd65;
	localparam logic [7:0] UPPER_Z  = 8'd90;
	localparam logic [7:0] CASE_OFS = 8'd32;
	localparam logic signed [8:0] LOWER_A_OFS = 9'sd96;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAG,
		ST_HRED,
		ST_BRED,
		ST_OUT
	} state_t;

	function automatic logic is_delim(input logic [7:0] b);
		logic r;
		unique case (b)
			8'h20, 8'h2e, 8'h2c, 8'h2d, 8'h3a,
			8'h21, 8'h22, 8'h27, 8'h28, 8'h29,
			8'h3b, 8'h40, 8'h5b, 8'h5d, 8'h3f: r = 1'b1;
			default:                         r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/word_tokenizer_bucket_hash_top.sv -----
// word tokenizer bucket hash: a word byte goes through accept, magnitude and 5 reduce steps
// a closing delimiter goes through accept, 30 bucket remainder steps and output
// a word byte with the end mark goes through its hash steps, the 30 steps and output
// both remainders run one step a cycle through the single compare-and-subtract unit
// result sits in an output register, so the next byte is taken while it waits
// arst_n clears the sequencer, the running hash, the output valid and bucket_count to 1
`default_nettype none

module word_tokenizer_bucket_hash_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  char_code,
	input  wire logic        end_of_sentence,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [23:0]      bucket_index,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import wtbh_pkg::*;

	state_t state_q, state_d;

	logic [BKT_W-1:0]   divisor;
	logic               word_open_q, word_open_d;
	logic               hneg_q, hneg_d;
	logic [MAG_W-1:0]   hmag_q, hmag_d;
	logic               neg_q, neg_d;
	logic               eos_q, eos_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic [REM_W-1:0]   rem_q, rem_d;
	logic signed [36:0] v_q, v_d;
	logic               out_valid_q, out_valid_d;
	logic [IDX_W-1:0]   bucket_q, bucket_d;

	logic [REM_W-1:0]   csu_a, csu_b, csu_diff;
	logic               csu_ge;
	logic               accept, slot_free;
	logic [7:0]         lc;
	logic signed [8:0]  digit;
	logic [34:0]        prod;
	logic signed [36:0] prod_s, digit_s;
	logic [REM_W-1:0]   rem_step;
	logic [25:0]        shifted;

	wtbh_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.divisor (divisor)
	);

	wtbh_csu u_csu (
		.a    (csu_a),
		.b    (csu_b),
		.ge   (csu_ge),
		.diff (csu_diff)
	);

	assign in_stall     = (state_q != ST_IDLE);
	assign accept       = in_valid && !in_stall;
	assign out_valid    = out_valid_q;
	assign bucket_index = bucket_q;
	assign slot_free    = !out_valid_q || !out_stall;

	// lowercase, read as signed char, offset by 'a' - 1
	assign lc      = (char_code >= UPPER_A && char_code <= UPPER_Z) ? char_code + CASE_OFS
	                                                                : char_code;
	assign digit   = $signed({lc[7], lc}) - LOWER_A_OFS;
	assign prod    = {hmag_q, 5'd0} - {5'd0, hmag_q};
	assign prod_s  = $signed({2'b00, prod});
	assign digit_s = 37'(digit);

	// restoring step for the bucket remainder brings in one hash bit
	assign shifted = {rem_q[24:0], hmag_q[cnt_q]};

	always_comb begin
		csu_a = rem_q;
		csu_b = HASH_MOD << cnt_q[2:0];
		if (state_q == ST_BRED) begin
			csu_a = REM_W'(shifted);
			csu_b = REM_W'(divisor);
		end
	end

	assign rem_step = csu_ge ? csu_diff : csu_a;

	always_comb begin
		state_d     = state_q;
		word_open_d = word_open_q;
		hneg_d      = hneg_q;
		hmag_d      = hmag_q;
		neg_d       = neg_q;
		eos_d       = eos_q;
		cnt_d       = cnt_q;
		rem_d       = rem_q;
		v_d         = v_q;
		out_valid_d = out_valid_q && out_stall;
		bucket_d    = bucket_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					eos_d = end_of_sentence;
					if (is_delim(char_code)) begin
						if (word_open_q) begin
							state_d = ST_BRED;
							rem_d   = '0;
							cnt_d   = BRED_TOP;
						end
					end else begin
						v_d     = hneg_q ? digit_s - prod_s : prod_s + digit_s;
						state_d = ST_MAG;
					end
				end
			end
			ST_MAG: begin
				neg_d   = v_q[36];
				rem_d   = v_q[36] ? REM_W'(-v_q) : v_q[REM_W-1:0];
				cnt_d   = HRED_TOP;
				state_d = ST_HRED;
			end
			ST_HRED: begin
				rem_d = rem_step;
				if (cnt_q == '0) begin
					hmag_d      = rem_step[MAG_W-1:0];
					hneg_d      = neg_q;
					word_open_d = 1'b1;
					if (eos_q) begin
						state_d = ST_BRED;
						rem_d   = '0;
						cnt_d   = BRED_TOP;
					end else begin
						state_d = ST_IDLE;
					end
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_BRED: begin
				rem_d = rem_step;
				if (cnt_q == '0) begin
					word_open_d = 1'b0;
					hneg_d      = 1'b0;
					hmag_d      = '0;
					state_d     = ST_OUT;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_OUT: begin
				if (slot_free) begin
					out_valid_d = 1'b1;
					bucket_d    = rem_q[IDX_W-1:0];
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			word_open_q <= 1'b0;
			hneg_q      <= 1'b0;
			hmag_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			word_open_q <= word_open_d;
			hneg_q      <= hneg_d;
			hmag_q      <= hmag_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		neg_q    <= neg_d;
		eos_q    <= eos_d;
		cnt_q    <= cnt_d;
		rem_q    <= rem_d;
		v_q      <= v_d;
		bucket_q <= bucket_d;
	end

	// running hash stays below the prime modulus
	a_hash_range: assert property (@(posedge clk) disable iff (!arst_n)
		REM_W'(hmag_q) < HASH_MOD)
		else $error("running hash out of range");

	// a closed word leaves a cleared hash
	a_closed_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!word_open_q |-> (hmag_q == '0 && !hneg_q))
		else $error("hash not cleared on closed word");

	// bucket remainder is below the divisor in the output state
	a_bucket_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |-> rem_q < REM_W'(divisor))
		else $error("bucket index not below bucket count");

	// a result is loaded only from the output state
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_OUT)
		else $error("result loaded outside output state");

endmodule

`default_nettype wire

// ----- rtl/core/wtbh_csu.sv -----
// shared compare-and-subtract unit used by both remainder loops
// depends on wtbh_pkg
`default_nettype none

module wtbh_csu (
	input  wire logic [wtbh_pkg::REM_W-1:0] a,
	input  wire logic [wtbh_pkg::REM_W-1:0] b,
	output logic                            ge,
	output logic [wtbh_pkg::REM_W-1:0]      diff
);
	import wtbh_pkg::*;

	logic [REM_W:0] sub;

	assign sub  = {1'b0, a} - {1'b0, b};
	assign ge   = ~sub[REM_W];
	assign diff = sub[REM_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/core/wtbh_apb.sv -----
// apb register slave holding the bucket count, with its clamped divisor
// depends on wtbh_pkg
`default_nettype none

module wtbh_apb (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [1:0]                 paddr,
	input  wire logic [31:0]                pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	output logic [wtbh_pkg::BKT_W-1:0]      divisor
);
	import wtbh_pkg::*;

	logic [BKT_W-1:0] bucket_count_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= BKT_W'(1);
		end else if (psel && penable && pwrite && pready && paddr == 2'd0) begin
			bucket_count_q <= pwdata[BKT_W-1:0];
		end
	end

	assign prdata = (paddr == 2'd0) ? {7'd0, bucket_count_q} : 32'd0;

	// zero counts as one bucket, large counts clamp to the index range
	always_comb begin
		priority if (bucket_count_q == '0) begin
			divisor = BKT_W'(1);
		end else if (bucket_count_q > BUCKET_MAX) begin
			divisor = BUCKET_MAX;
		end else begin
			divisor = bucket_count_q;
		end
	end

endmodule

`default_nettype wire
